// ===== sv/integer_to_ascii_digits_core_assert.svh =====
// assertion macros for the integer to ascii digits core
// both sample on clk and are held off while rst_n is low
`ifndef INTEGER_TO_ASCII_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define I2A_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the following cycle
`define I2A_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2a_pkg.sv =====
`timescale 1ns / 1ps

package i2a_pkg;

    // port field widths
    localparam int VALUE_FIELD_W = 64;
    localparam int BSIZE_W       = 6;
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 5;
    localparam int DIGIT_W       = 4;

    // operand bits used (8..64) and cells in the digit row (3..20)
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 20;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    localparam logic [CHAR_W-1:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // what each digit cell does this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DEC,
        CELL_HEX,
        CELL_MOVE
    } cell_mode_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] d);
        return HEX_CHARS[d];
    endfunction

endpackage

// ===== sv/i2a_in_if.sv =====
`timescale 1ns / 1ps

interface i2a_in_if;

    logic                                valid;
    logic                                ready;
    logic [i2a_pkg::VALUE_FIELD_W-1:0]   value;
    logic                                is_signed;
    logic                                base_is_hex;
    logic [i2a_pkg::BSIZE_W-1:0]         dest_bytes;

    modport source (
        output valid,
        output value,
        output is_signed,
        output base_is_hex,
        output dest_bytes,
        input  ready
    );

    modport sink (
        input  valid,
        input  value,
        input  is_signed,
        input  base_is_hex,
        input  dest_bytes,
        output ready
    );

endinterface

// ===== sv/i2a_out_if.sv =====
`timescale 1ns / 1ps

interface i2a_out_if;

    logic                          valid;
    logic                          ready;
    logic [i2a_pkg::CHAR_W-1:0]    out_char;
    logic                          is_last;
    logic                          is_empty;
    logic [i2a_pkg::LEN_W-1:0]     char_total;

    modport source (
        output valid,
        output out_char,
        output is_last,
        output is_empty,
        output char_total,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_char,
        input  is_last,
        input  is_empty,
        input  char_total,
        output ready
    );

endinterface

// ===== sv/integer_to_ascii_digits_core.sv =====
`timescale 1ns / 1ps
// channel   dir   word                                              handshake
// number    in    value, is_signed, base_is_hex, dest_bytes         valid/ready
// text      out   out_char, is_last, is_empty, char_total           valid/ready
//
// one conversion at a time; a new number is taken once the last character is in the
// output register. the operand passes through the digit cell row in VALUE_WIDTH
// single-bit shifts; with no room a single empty word is sent.
// rst_n is asynchronous and clears all control; a stalled text word holds the fsm.
`include "integer_to_ascii_digits_core_assert.svh"

module integer_to_ascii_digits_core (
    input  logic        clk,
    input  logic        rst_n,
    i2a_in_if.sink      number,
    i2a_out_if.source   text
);

    localparam int VW        = i2a_pkg::VALUE_WIDTH;
    localparam int MD        = i2a_pkg::MAX_DIGITS;
    localparam int BIT_CNT_W = $clog2(VW + 1);
    localparam int CNT_W     = $clog2(MD + 1);
    localparam int DW        = i2a_pkg::DIGIT_W;
    localparam int LW        = i2a_pkg::LEN_W;
    localparam int CW        = i2a_pkg::CHAR_W;
    localparam int BW        = i2a_pkg::BSIZE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t                 state_reg, state_next;
    logic [VW-1:0]          bits_reg, bits_next;        // operand magnitude, msb shifted out
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;          // digits still in the row
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic [LW-1:0]          total_reg, total_next;
    logic                   neg_reg, neg_next;
    logic                   hex_reg, hex_next;
    logic                   seen_reg, seen_next;        // a significant digit sits above the top
    logic                   sign_pend_reg, sign_pend_next;

    // output register
    logic                   oval_reg, oval_next;
    logic [CW-1:0]          ochar_reg, ochar_next;
    logic                   olast_reg, olast_next;
    logic                   oempty_reg, oempty_next;
    logic [LW-1:0]          olen_reg, olen_next;

    // digit cell row, cell 0 least significant
    i2a_pkg::cell_mode_t    cell_mode;
    logic [DW-1:0]          digit_w [MD];
    logic                   carry_w [MD];
    logic [DW-1:0]          din_w   [MD];
    logic                   cin_w   [MD];

    genvar gi;
    generate
        for (gi = 0; gi < MD; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign cin_w[gi] = bits_reg[VW-1];
                assign din_w[gi] = '0;
            end
            else
            begin : g_rest
                assign cin_w[gi] = carry_w[gi-1];
                assign din_w[gi] = digit_w[gi-1];
            end

            i2a_cell u_cell (
                .clk       (clk),
                .mode      (cell_mode),
                .carry_in  (cin_w[gi]),
                .digit_in  (din_w[gi]),
                .digit     (digit_w[gi]),
                .carry_out (carry_w[gi])
            );
        end
    endgenerate

    logic [DW-1:0]          top_digit;
    logic                   top_carry;
    logic [VW-1:0]          field;
    logic                   neg_in;
    logic [VW-1:0]          mag;
    logic [BW-1:0]          limit_raw;
    logic [CNT_W-1:0]       limit_clip;
    logic                   slot_free;
    logic                   seen_now;
    logic                   keep_sign;

    assign top_digit = digit_w[MD-1];
    assign top_carry = carry_w[MD-1];

    // operand decode for the incoming word
    assign field  = number.value[VW-1:0];
    assign neg_in = number.is_signed & ~number.base_is_hex & field[VW-1];
    assign mag    = neg_in ? VW'(~field + VW'(1)) : field;

    // characters that fit: buffer size less the terminator, capped at the row length
    assign limit_raw  = (number.dest_bytes == '0) ? '0
                      : number.dest_bytes - BW'(1);
    assign limit_clip = (limit_raw > BW'(MD)) ? CNT_W'(MD)
                      : limit_raw[CNT_W-1:0];

    assign slot_free = !oval_reg || text.ready;
    assign seen_now  = seen_reg || (top_digit != '0);
    assign keep_sign = neg_reg && (cnt_reg < limit_reg);

    assign number.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        bits_next      = bits_reg;
        bit_cnt_next   = bit_cnt_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        total_next     = total_reg;
        neg_next       = neg_reg;
        hex_next       = hex_reg;
        seen_next      = seen_reg;
        sign_pend_next = sign_pend_reg;
        oval_next      = oval_reg;
        ochar_next     = ochar_reg;
        olast_next     = olast_reg;
        oempty_next    = oempty_reg;
        olen_next      = olen_reg;
        cell_mode      = i2a_pkg::CELL_HOLD;

        if (oval_reg && text.ready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (number.valid)
                begin
                    neg_next   = neg_in;
                    hex_next   = number.base_is_hex;
                    limit_next = limit_clip;
                    if (limit_clip == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        bits_next    = mag;
                        bit_cnt_next = BIT_CNT_W'(VW);
                        seen_next    = 1'b0;
                        cell_mode    = i2a_pkg::CELL_CLEAR;
                        state_next   = ST_CONVERT;
                    end
                end
            end

            // one operand bit enters cell 0 per cycle; carries out of the top are remembered
            ST_CONVERT:
            begin
                cell_mode    = hex_reg ? i2a_pkg::CELL_HEX : i2a_pkg::CELL_DEC;
                bits_next    = bits_reg << 1;
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                seen_next    = seen_reg | top_carry;
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(MD);
                    state_next = ST_TRIM;
                end
            end

            // drop leading zeros and the digits that do not fit, one per cycle
            ST_TRIM:
            begin
                if ((cnt_reg > limit_reg) || (!seen_now && cnt_reg > CNT_W'(1)))
                begin
                    cell_mode = i2a_pkg::CELL_MOVE;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    seen_next = seen_now;
                end
                else
                begin
                    sign_pend_next = keep_sign;
                    total_next     = LW'(cnt_reg) + LW'(keep_sign);
                    state_next     = ST_EMIT;
                end
            end

            // sign first, then the top cell each cycle that the output slot is free, as the row moves up
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    oval_next   = 1'b1;
                    oempty_next = 1'b0;
                    olen_next   = total_reg;
                    if (sign_pend_reg)
                    begin
                        ochar_next     = i2a_pkg::CHAR_MINUS;
                        olast_next     = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        ochar_next = i2a_pkg::hex_char(top_digit);
                        cell_mode  = i2a_pkg::CELL_MOVE;
                        cnt_next   = cnt_reg - CNT_W'(1);
                        olast_next = (cnt_reg == CNT_W'(1));
                        if (cnt_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            // no room at all: a single empty word
            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    oval_next   = 1'b1;
                    ochar_next  = i2a_pkg::CHAR_NONE;
                    olast_next  = 1'b1;
                    oempty_next = 1'b1;
                    olen_next   = '0;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bits_reg      <= '0;
            bit_cnt_reg   <= '0;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            total_reg     <= '0;
            neg_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            sign_pend_reg <= 1'b0;
            oval_reg      <= 1'b0;
            ochar_reg     <= '0;
            olast_reg     <= 1'b0;
            oempty_reg    <= 1'b0;
            olen_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_reg      <= bits_next;
            bit_cnt_reg   <= bit_cnt_next;
            cnt_reg       <= cnt_next;
            limit_reg     <= limit_next;
            total_reg     <= total_next;
            neg_reg       <= neg_next;
            hex_reg       <= hex_next;
            seen_reg      <= seen_next;
            sign_pend_reg <= sign_pend_next;
            oval_reg      <= oval_next;
            ochar_reg     <= ochar_next;
            olast_reg     <= olast_next;
            oempty_reg    <= oempty_next;
            olen_reg      <= olen_next;
        end
    end

    assign text.valid      = oval_reg;
    assign text.out_char   = ochar_reg;
    assign text.is_last    = olast_reg;
    assign text.is_empty   = oempty_reg;
    assign text.char_total = olen_reg;

    // row count stays within what the buffer allows while characters go out
    `I2A_ASSERT_NOW(a_emit_count, state_reg == ST_EMIT, (cnt_reg != '0) && (cnt_reg <= limit_reg), "digit count out of range while emitting")
    // decimal cells hold proper bcd once the shifts are done
    `I2A_ASSERT_NOW(a_bcd_digit, (state_reg == ST_TRIM) && !hex_reg, top_digit <= 4'd9, "top cell holds a non-decimal digit")
    // an empty word is alone and carries no length
    `I2A_ASSERT_NOW(a_empty_word, text.valid && text.is_empty, text.is_last && (text.char_total == '0), "empty word not final or with length")
    // a minus sign is never the only or the final character
    `I2A_ASSERT_NOW(a_sign_word, text.valid && !text.is_empty && (text.out_char == i2a_pkg::CHAR_MINUS), !text.is_last && (text.char_total >= LW'(2)), "minus sign word malformed")
    // the last shift hands a full row to the trim pass
    `I2A_ASSERT_NXT(a_convert_end, (state_reg == ST_CONVERT) && (bit_cnt_reg == BIT_CNT_W'(1)), (state_reg == ST_TRIM) && (cnt_reg == CNT_W'(MD)), "conversion did not end in trim")

endmodule

// ===== sv/i2a_cell.sv =====
`timescale 1ns / 1ps

module i2a_cell (
    input  logic                           clk,
    input  i2a_pkg::cell_mode_t            mode,
    input  logic                           carry_in,
    input  logic [i2a_pkg::DIGIT_W-1:0]    digit_in,
    output logic [i2a_pkg::DIGIT_W-1:0]    digit,
    output logic                           carry_out
);

    logic [i2a_pkg::DIGIT_W-1:0] digit_reg;
    logic [i2a_pkg::DIGIT_W-1:0] digit_next;
    logic [i2a_pkg::DIGIT_W-1:0] adj;

    // add-3 correction before the shift in decimal mode
    always_comb
    begin
        if (mode == i2a_pkg::CELL_DEC && digit_reg >= 4'd5)
        begin
            adj = digit_reg + 4'd3;
        end
        else
        begin
            adj = digit_reg;
        end
    end

    assign carry_out = adj[i2a_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        case (mode)
            i2a_pkg::CELL_HOLD:  digit_next = digit_reg;
            i2a_pkg::CELL_CLEAR: digit_next = '0;
            i2a_pkg::CELL_DEC:   digit_next = {adj[i2a_pkg::DIGIT_W-2:0], carry_in};
            i2a_pkg::CELL_HEX:   digit_next = {adj[i2a_pkg::DIGIT_W-2:0], carry_in};
            i2a_pkg::CELL_MOVE:  digit_next = digit_in;
            default:             digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== tb/integer_to_ascii_digits_core_test.sv =====
`timescale 1ns / 1ps

module integer_to_ascii_digits_core_test;

    import i2a_pkg::*;

    // run limits, in clock cycles
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;    // a little above one full 64-bit conversion
    localparam int HOLD_CYCLES   = 400;    // long receiver hold, several conversions long
    localparam int PHASE_WORDS   = 105;    // random numbers per idling phase

    localparam logic [VALUE_FIELD_W-1:0] OPERAND_MASK =
        {VALUE_FIELD_W{1'b1}} >> (VALUE_FIELD_W - VALUE_WIDTH);
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = "0";
    localparam logic [CHAR_W-1:0] ASCII_A_LOWER = "a";

    // one character word as it should appear on the text channel
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        logic [LEN_W-1:0]  len;
    } text_word_t;

    // scoreboard: renders each accepted number into its expected characters
    // and compares the text words against them in order
    class digit_text_board;
        text_word_t expected_chars[$];
        int         failures;
        int         numbers;
        int         chars;
        int         empties;

        function new();
            failures = 0;
            numbers  = 0;
            chars    = 0;
            empties  = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function logic [CHAR_W-1:0] digit_ascii(logic [DIGIT_W-1:0] d);
            return (d < 10) ? ASCII_ZERO + CHAR_W'(d) : ASCII_A_LOWER + CHAR_W'(d - 10);
        endfunction

        function void note_number(logic [VALUE_FIELD_W-1:0] value, logic sgn, logic hex,
                                  logic [BSIZE_W-1:0] bsize);
            logic [VALUE_FIELD_W-1:0] mag;
            logic                     neg;
            int unsigned              room;
            int unsigned              kept;
            int unsigned              total;
            logic [DIGIT_W-1:0]       digit_row [MAX_DIGITS];

            numbers++;
            mag  = value & OPERAND_MASK;
            room = (bsize == 0) ? 0 : bsize - 1;
            if (room > MAX_DIGITS)
                room = MAX_DIGITS;

            // minus only for signed decimal, hex shows the raw pattern
            neg = sgn && !hex && mag[VALUE_WIDTH-1];
            if (neg)
                mag = (~mag + 1'b1) & OPERAND_MASK;

            // nothing fits: a single empty word
            if (room == 0)
            begin
                expected_chars.push_back('{CHAR_NONE, 1'b1, 1'b1, LEN_W'(0)});
                return;
            end

            // least significant digits first, stopping when the buffer is full
            kept = 0;
            if (mag == 0)
            begin
                digit_row[0] = '0;
                kept = 1;
            end
            else
            begin
                while (mag != 0 && kept < room)
                begin
                    if (hex)
                    begin
                        digit_row[kept] = mag[DIGIT_W-1:0];
                        mag = mag >> DIGIT_W;
                    end
                    else
                    begin
                        digit_row[kept] = DIGIT_W'(mag % 10);
                        mag = mag / 10;
                    end
                    kept++;
                end
            end

            // the sign is dropped when there is no room left for it
            if (neg && kept >= room)
                neg = 1'b0;
            total = kept + neg;

            if (neg)
                expected_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0, LEN_W'(total)});
            for (int i = kept - 1; i >= 0; i--)
                expected_chars.push_back('{digit_ascii(digit_row[i]), (i == 0), 1'b0,
                                           LEN_W'(total)});
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last, logic empty,
                                 logic [LEN_W-1:0] len);
            text_word_t w;

            if (expected_chars.size() == 0)
            begin
                $error("text word with nothing pending: out_char %h", ch);
                failures++;
                return;
            end
            w = expected_chars.pop_front();
            chars++;
            if (w.empty)
                empties++;
            // out_char carries no meaning on an empty word
            if (!w.empty && ch !== w.ch)
            begin
                $error("out_char expected %h actual %h", w.ch, ch);
                failures++;
            end
            if (last !== w.last)
            begin
                $error("is_last expected %b actual %b", w.last, last);
                failures++;
            end
            if (empty !== w.empty)
            begin
                $error("is_empty expected %b actual %b", w.empty, empty);
                failures++;
            end
            if (len !== w.len)
            begin
                $error("char_total expected %0d actual %0d", w.len, len);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    i2a_in_if  number_ch ();
    i2a_out_if text_ch ();

    integer_to_ascii_digits_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    digit_text_board board = new();

    int   send_idle_pct;      // chance in a hundred that the sender idles a cycle
    int   recv_stall_pct;     // chance in a hundred that the receiver stalls a cycle
    logic long_hold;          // receiver held off by the hold process
    int   cycle_count;
    event hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a correct run finishes well within the limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // long receiver hold, counted here so the sender keeps pushing numbers
    initial
    begin
        long_hold = 1'b0;
        forever
        begin
            @(hold_request);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    // text receiver: check each accepted word, then choose ready for the next cycle
    initial
    begin
        text_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && text_ch.valid && text_ch.ready)
                board.check_char(text_ch.out_char, text_ch.is_last, text_ch.is_empty,
                                 text_ch.char_total);
            if (long_hold)
                text_ch.ready <= 1'b0;
            else
                text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one number, with random idle cycles ahead of it, and wait for acceptance;
    // valid stays high afterwards so back-to-back numbers need no second assignment
    task send_number(input logic [VALUE_FIELD_W-1:0] value, input logic sgn,
                     input logic hex, input logic [BSIZE_W-1:0] bsize);
        while ($urandom_range(99) < send_idle_pct)
        begin
            number_ch.valid <= 1'b0;
            @(posedge clk);
        end
        number_ch.valid       <= 1'b1;
        number_ch.value       <= value;
        number_ch.is_signed   <= sgn;
        number_ch.base_is_hex <= hex;
        number_ch.dest_bytes  <= bsize;
        @(posedge clk);
        while (!number_ch.ready)
            @(posedge clk);
        board.note_number(value, sgn, hex, bsize);
    endtask

    // operands spread over magnitudes, decimal boundaries and sign patterns
    function logic [VALUE_FIELD_W-1:0] pick_operand();
        logic [VALUE_FIELD_W-1:0] p;

        p = 1;
        case ($urandom_range(7))
            0: return {$urandom, $urandom};
            1: return VALUE_FIELD_W'($urandom_range(1000));
            2:
            begin
                // a power of ten, give or take one
                repeat ($urandom_range(19)) p = p * 10;
                return p + $urandom_range(2) - 1;
            end
            3: return -VALUE_FIELD_W'($urandom_range(100000));
            4: return {$urandom, $urandom} >> $urandom_range(63);
            5: return -({$urandom, $urandom} >> $urandom_range(63));
            6: return {1'b1, {(VALUE_FIELD_W-1){1'b0}}} + $urandom_range(3);
            default: return {VALUE_FIELD_W{1'b1}} - $urandom_range(3);
        endcase
    endfunction

    // buffer sizes: mostly short, so truncation and sign dropping are common,
    // with the out-of-range codes at both ends too
    function logic [BSIZE_W-1:0] pick_buffer_size();
        case ($urandom_range(9))
            0:       return BSIZE_W'($urandom_range(1));
            1:       return BSIZE_W'($urandom_range(63, 33));
            2, 3:    return BSIZE_W'($urandom_range(32, 21));
            default: return BSIZE_W'($urandom_range(20, 2));
        endcase
    endfunction

    // stop offering and let every pending word come out, then a latency's worth more
    task settle();
        number_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task run_phase(input int words, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (words)
            send_number(pick_operand(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                        pick_buffer_size());
        settle();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        number_ch.valid       = 1'b0;
        number_ch.value       = '0;
        number_ch.is_signed   = 1'b0;
        number_ch.base_is_hex = 1'b0;
        number_ch.dest_bytes  = '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, full range, sign handling, short and oversized buffers
        send_number(64'd0, 1'b0, 1'b0, 6'd32);
        send_number(64'd0, 1'b1, 1'b1, 6'd2);
        send_number({64{1'b1}}, 1'b0, 1'b0, 6'd32);        // twenty decimal digits
        send_number({64{1'b1}}, 1'b0, 1'b1, 6'd32);
        send_number(-64'd1, 1'b1, 1'b0, 6'd32);            // minus one
        send_number(-64'd1, 1'b1, 1'b1, 6'd32);            // hex keeps the raw pattern
        send_number({1'b1, 63'd0}, 1'b1, 1'b0, 6'd32);     // most negative value
        send_number({1'b1, 63'd0}, 1'b1, 1'b1, 6'd32);
        send_number({1'b1, 63'd0}, 1'b1, 1'b0, 6'd20);     // digits fill, sign dropped
        send_number(64'd12345, 1'b0, 1'b0, 6'd0);          // no room at all
        send_number(-64'd7, 1'b1, 1'b0, 6'd1);
        send_number(64'd0, 1'b1, 1'b0, 6'd1);
        send_number(64'd12345, 1'b0, 1'b0, 6'd2);          // only the last digit kept
        send_number(-64'd123, 1'b1, 1'b0, 6'd4);           // no room for the sign
        send_number(-64'd123, 1'b1, 1'b0, 6'd5);           // sign just fits
        send_number(-64'd123, 1'b1, 1'b0, 6'd2);
        send_number(64'd42, 1'b1, 1'b0, 6'd63);            // signed positive, size clamped
        send_number(64'hdeadbeefcafef00d, 1'b0, 1'b1, 6'd33);
        send_number(64'd9, 1'b0, 1'b0, 6'd3);
        send_number(64'd10, 1'b0, 1'b0, 6'd3);
        send_number(64'hf, 1'b0, 1'b1, 6'd3);
        send_number(64'h10, 1'b0, 1'b1, 6'd3);
        send_number(64'hfedcba9876543210, 1'b0, 1'b1, 6'd9);
        settle();

        // no idling, but the receiver is held off long enough to back the block up
        -> hold_request;
        run_phase(PHASE_WORDS, 0, 0);
        run_phase(PHASE_WORDS, 83, 0);
        run_phase(PHASE_WORDS, 0, 83);
        run_phase(PHASE_WORDS, 30, 30);

        $display("checked %0d numbers as %0d text words, %0d of them with no room",
                 board.numbers, board.chars, board.empties);
        $display("decimal and hex, signed and unsigned, buffers 0 to 63, four idling phases");
        if (board.failures == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
